// ----- rtl/kols_pkg.sv -----
// ----------------------------------------------------------------------------
// kols_pkg
// Shared types and constants for the keyed ordered list store.
// ----------------------------------------------------------------------------
package kols_pkg;

   localparam int KEY_W   = 32;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      CMD_PUSH     = 2'd0,
      CMD_POP      = 2'd1,
      CMD_CONTAINS = 2'd2,
      CMD_REMOVE   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] payload;
   } entry_type;

   // per-beat control broadcast to every cell
   typedef struct packed {
      logic             push;
      logic             pop;
      logic             remove;
      logic [KEY_W-1:0] key;
   } ctl_type;

endpackage

// ----- rtl/kols_cell.sv -----
// ----------------------------------------------------------------------------
// kols_cell
// One slot of the list: holds a record, compares its key, and shifts toward
// the back on push or toward the front on pop and on remove at or behind a match.
// ----------------------------------------------------------------------------
module kols_cell (
   input  logic                clock,
   input  kols_pkg::ctl_type   ctl,
   input  logic                occupied,
   input  kols_pkg::entry_type left_entry,
   input  kols_pkg::entry_type right_entry,
   input  logic                hit_before,
   output logic                hit_through,
   output kols_pkg::entry_type entry_ff,
   output kols_pkg::entry_type entry_in
);

   logic hit;
   logic shift_front;

   assign hit         = occupied && (entry_ff.key == ctl.key);
   assign hit_through = hit_before || hit;
   assign shift_front = ctl.pop || (ctl.remove && hit_through);

   always_comb begin
      if (ctl.push) begin
         entry_in = left_entry;
      end else if (shift_front) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- rtl/keyed_ordered_list_store_top.sv -----
// ----------------------------------------------------------------------------
// keyed_ordered_list_store_top
// Ordered store of up to DEPTH key/payload records built as a row of cells.
// ----------------------------------------------------------------------------
// Each request beat is one command (push front, pop front, contains, remove
// first match) and yields exactly one response beat that reports the found
// and error flags, the record count and the front record after the command.
// One command completes per clock: every cell compares its key against the
// request in parallel and moves its record one slot locally, so a new request
// is taken every cycle as long as the response register is drained. Results
// are registered and appear in the cycle after acceptance. Records are not
// cleared at reset; only the count and the response valid flag are.
module keyed_ordered_list_store_top #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_key,
   input  logic [31:0] req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic        rsp_error,
   output logic        rsp_is_empty,
   output logic [4:0]  rsp_count,
   output logic [31:0] rsp_front_key,
   output logic [31:0] rsp_front_payload
);

   localparam int CW = $clog2(DEPTH + 1);

   kols_pkg::cmd_type   cmd;
   kols_pkg::ctl_type   ctl;
   kols_pkg::entry_type req_entry;
   kols_pkg::entry_type entry_ff [DEPTH];
   kols_pkg::entry_type entry_in [DEPTH];
   logic [DEPTH:0]      hit_chain;

   logic          req_fire;
   logic          full;
   logic          empty;
   logic          found;
   logic          error;
   logic [CW-1:0] count_ff, count_in;
   logic [CW+4:0] count_ext;

   logic                       rsp_valid_ff;
   logic                       found_ff;
   logic                       error_ff;
   logic                       is_empty_ff;
   logic [kols_pkg::COUNT_W-1:0] count_out_ff;
   kols_pkg::entry_type        front_ff;
   kols_pkg::entry_type        front_in;

   assign cmd       = kols_pkg::cmd_type'(req_command);
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);

   assign req_entry.key     = req_key;
   assign req_entry.payload = req_payload;

   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      kols_pkg::entry_type left_entry;
      kols_pkg::entry_type right_entry;
      if (i == 0) begin : g_first
         assign left_entry = req_entry;
      end else begin : g_mid
         assign left_entry = entry_ff[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_entry = entry_ff[i];
      end else begin : g_notlast
         assign right_entry = entry_ff[i+1];
      end
      kols_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (count_ff > CW'(i)),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .hit_before  (hit_chain[i]),
         .hit_through (hit_chain[i+1]),
         .entry_ff    (entry_ff[i]),
         .entry_in    (entry_in[i])
      );
   end

   always_comb begin
      ctl      = '0;
      ctl.key  = req_key;
      found    = 1'b0;
      error    = 1'b0;
      count_in = count_ff;
      unique case (cmd)
         kols_pkg::CMD_PUSH: begin
            error    = full;
            ctl.push = req_fire && !full;
            if (!full) count_in = count_ff + CW'(1);
         end
         kols_pkg::CMD_POP: begin
            error   = empty;
            ctl.pop = req_fire && !empty;
            if (!empty) count_in = count_ff - CW'(1);
         end
         kols_pkg::CMD_CONTAINS: begin
            found = hit_chain[DEPTH];
         end
         kols_pkg::CMD_REMOVE: begin
            found      = hit_chain[DEPTH];
            ctl.remove = req_fire;
            if (hit_chain[DEPTH]) count_in = count_ff - CW'(1);
         end
         default: begin
         end
      endcase
      front_in = (count_in == '0) ? '0 : entry_in[0];
   end

   assign count_ext = {5'd0, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         found_ff     <= found;
         error_ff     <= error;
         is_empty_ff  <= (count_in == '0);
         count_out_ff <= count_ext[kols_pkg::COUNT_W-1:0];
         front_ff     <= front_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_error         = error_ff;
   assign rsp_is_empty      = is_empty_ff;
   assign rsp_count         = count_out_ff;
   assign rsp_front_key     = front_ff.key;
   assign rsp_front_payload = front_ff.payload;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("record count exceeds depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      req_fire && cmd == kols_pkg::CMD_PUSH && !full
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("push did not add a record");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(found_ff && error_ff))
      else $error("found and error both set");

   a_push_front: assert property (@(posedge clock) disable iff (reset)
      req_fire && cmd == kols_pkg::CMD_PUSH && !full
      |=> entry_ff[0].key == $past(req_key) && front_ff.key == $past(req_key))
      else $error("pushed record not at front");

   a_miss_holds: assert property (@(posedge clock) disable iff (reset)
      req_fire && cmd == kols_pkg::CMD_REMOVE && !hit_chain[DEPTH]
      |=> $stable(count_ff))
      else $error("remove of absent key changed count");

endmodule
